>>> rtl/tdmh_pkg.sv
// Shared types, constants and helper functions for the Tandem-DM CHAM hash block.
// No dependencies; every other file in the project depends on this package.
package tdmh_pkg;

    localparam int WORD_W         = 32;
    localparam int ROUND_W        = 8;
    localparam int BLOCK_WORDS    = 4;
    localparam int KEY_WORDS      = 8;
    localparam int KEY_SEL_W      = 3;
    localparam int RK_SEL_W       = 4;
    localparam int ROUNDS_DEFAULT = 120;

    localparam int ROT_A  = 1;
    localparam int ROT_B  = 8;
    localparam int ROT_KS = 11;

    typedef logic [WORD_W-1:0] word_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PASS1,
        ST_PASS2,
        ST_DONE
    } state_t;

    // Rotate left by a constant amount between 1 and WORD_W-1.
    function automatic word_t rotl(input word_t x, input int unsigned n);
        return (x << n) | (x >> (WORD_W - n));
    endfunction

endpackage

>>> rtl/tdmh_blk_if.sv
// Request channel carrying one 128-bit message block and its last-block flag.
// Depends on tdmh_pkg for the word width.
interface tdmh_blk_if;
    logic                   valid;
    logic                   ready;
    logic [tdmh_pkg::WORD_W-1:0] block_word0;
    logic [tdmh_pkg::WORD_W-1:0] block_word1;
    logic [tdmh_pkg::WORD_W-1:0] block_word2;
    logic [tdmh_pkg::WORD_W-1:0] block_word3;
    logic                   last_block;

    modport source (output valid, block_word0, block_word1, block_word2, block_word3,
                    last_block, input ready);
    modport sink   (input valid, block_word0, block_word1, block_word2, block_word3,
                    last_block, output ready);
endinterface

>>> rtl/tdmh_dig_if.sv
// Request channel carrying one 256-bit digest as eight 32-bit words.
// Depends on tdmh_pkg for the word width.
interface tdmh_dig_if;
    logic                   valid;
    logic                   ready;
    logic [tdmh_pkg::WORD_W-1:0] digest_h0;
    logic [tdmh_pkg::WORD_W-1:0] digest_h1;
    logic [tdmh_pkg::WORD_W-1:0] digest_h2;
    logic [tdmh_pkg::WORD_W-1:0] digest_h3;
    logic [tdmh_pkg::WORD_W-1:0] digest_g0;
    logic [tdmh_pkg::WORD_W-1:0] digest_g1;
    logic [tdmh_pkg::WORD_W-1:0] digest_g2;
    logic [tdmh_pkg::WORD_W-1:0] digest_g3;

    modport source (output valid, digest_h0, digest_h1, digest_h2, digest_h3,
                    digest_g0, digest_g1, digest_g2, digest_g3, input ready);
    modport sink   (input valid, digest_h0, digest_h1, digest_h2, digest_h3,
                    digest_g0, digest_g1, digest_g2, digest_g3, output ready);
endinterface

>>> rtl/tandem_dm_hash_cham.sv
// Tandem-DM hash over CHAM-128/256: a message block is taken only while the sequencer
// is idle, which it is again once both encryptions of the block are done, and for a
// block that closes a message only after its digest has moved to the output register.
// The single CHAM round unit runs one round per cycle for both encryptions of a block.
// Asynchronous active-low reset clears the chain to zero, empties the output register
// and returns the sequencer to idle.
module tandem_dm_hash_cham #(
    parameter int ROUNDS = tdmh_pkg::ROUNDS_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    tdmh_blk_if.sink   blk,
    tdmh_dig_if.source digest
);
    import tdmh_pkg::*;

    // Sequencer state and round counter.
    state_t               state_reg, state_next;
    logic [ROUND_W-1:0]   round_reg, round_next;

    // Cipher working words, the 256-bit cipher key, and the flag of the current request.
    word_t                cw_reg   [BLOCK_WORDS];
    word_t                cw_next  [BLOCK_WORDS];
    word_t                key_reg  [KEY_WORDS];
    word_t                key_next [KEY_WORDS];
    logic                 last_reg, last_next;

    // The Tandem-DM chain halves H and G.
    word_t                h_reg    [BLOCK_WORDS];
    word_t                h_next   [BLOCK_WORDS];
    word_t                g_reg    [BLOCK_WORDS];
    word_t                g_next   [BLOCK_WORDS];

    // Output register, which lets the next message start while a digest waits.
    logic                 out_valid_reg, out_valid_next;
    word_t                out_h_reg  [BLOCK_WORDS];
    word_t                out_h_next [BLOCK_WORDS];
    word_t                out_g_reg  [BLOCK_WORDS];
    word_t                out_g_next [BLOCK_WORDS];

    // Control decoded from the state.
    logic                 blk_take;
    logic                 last_round;
    logic                 out_free;
    logic                 out_load;

    // Shared round unit.
    logic [RK_SEL_W-1:0]  rk_sel;
    word_t                rk_word;
    word_t                rk;
    word_t                mixed;
    word_t                sum;
    word_t                t;
    word_t                cw_round [BLOCK_WORDS];

    // ---------------------------------------------------------------------
    // Round key on the fly. Round r uses key r mod 16. The first eight keys
    // come from key word j rotated by 1 and 8; the upper eight come from key
    // word (j xor 1) rotated by 1 and 11, which is the pairwise swap of the
    // CHAM key schedule.
    // ---------------------------------------------------------------------
    assign rk_sel  = round_reg[RK_SEL_W-1:0];

    always_comb
    begin
        if (rk_sel[RK_SEL_W-1])
        begin
            rk_word = key_reg[rk_sel[KEY_SEL_W-1:0] ^ KEY_SEL_W'(1)];
            rk      = rk_word ^ rotl(rk_word, ROT_A) ^ rotl(rk_word, ROT_KS);
        end
        else
        begin
            rk_word = key_reg[rk_sel[KEY_SEL_W-1:0]];
            rk      = rk_word ^ rotl(rk_word, ROT_A) ^ rotl(rk_word, ROT_B);
        end
    end

    // One CHAM round: even rounds rotate by 1 then 8, odd rounds by 8 then 1.
    always_comb
    begin
        if (round_reg[0])
            mixed = rotl(cw_reg[1], ROT_B) ^ rk;
        else
            mixed = rotl(cw_reg[1], ROT_A) ^ rk;
        sum = (cw_reg[0] ^ WORD_W'(round_reg)) + mixed;
        if (round_reg[0])
            t = rotl(sum, ROT_A);
        else
            t = rotl(sum, ROT_B);
        cw_round[0] = cw_reg[1];
        cw_round[1] = cw_reg[2];
        cw_round[2] = cw_reg[3];
        cw_round[3] = t;
    end

    // ---------------------------------------------------------------------
    // Sequencer: next state.
    // ---------------------------------------------------------------------
    assign last_round = (round_reg == ROUND_W'(ROUNDS - 1));
    assign out_free   = !out_valid_reg || digest.ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (blk.valid)
                    state_next = ST_PASS1;
            end
            ST_PASS1:
            begin
                if (last_round)
                    state_next = ST_PASS2;
            end
            ST_PASS2:
            begin
                if (last_round)
                    state_next = last_reg ? ST_DONE : ST_IDLE;
            end
            ST_DONE:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Sequencer: outputs. The block takes a request only when idle, and a
    // finished digest moves to the output register as soon as it is free.
    always_comb
    begin
        blk_take = 1'b0;
        out_load = 1'b0;
        unique case (state_reg)
            ST_IDLE:  blk_take = blk.valid;
            ST_DONE:  out_load = out_free;
            default:
            begin
                blk_take = 1'b0;
                out_load = 1'b0;
            end
        endcase
    end

    assign blk.ready = (state_reg == ST_IDLE);

    // ---------------------------------------------------------------------
    // Datapath next values.
    // First pass encrypts H under G||M to give W. At its end the key becomes
    // M||W (M is still in the upper key half) and G is loaded as plaintext.
    // At the end of the second pass H is XORed with W, still held in the upper key
    // half, and G is XORed with the fresh ciphertext.
    // ---------------------------------------------------------------------
    always_comb
    begin
        round_next     = round_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg;
        cw_next        = cw_reg;
        key_next       = key_reg;
        h_next         = h_reg;
        g_next         = g_reg;
        out_h_next     = out_h_reg;
        out_g_next     = out_g_reg;

        if (digest.ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (blk_take)
                begin
                    round_next  = '0;
                    last_next   = blk.last_block;
                    cw_next     = h_reg;
                    for (int i = 0; i < BLOCK_WORDS; i++)
                        key_next[i] = g_reg[i];
                    key_next[4] = blk.block_word0;
                    key_next[5] = blk.block_word1;
                    key_next[6] = blk.block_word2;
                    key_next[7] = blk.block_word3;
                end
            end
            ST_PASS1:
            begin
                round_next = round_reg + ROUND_W'(1);
                cw_next    = cw_round;
                if (last_round)
                begin
                    round_next = '0;
                    cw_next    = g_reg;
                    for (int i = 0; i < BLOCK_WORDS; i++)
                    begin
                        key_next[i]               = key_reg[i + BLOCK_WORDS];
                        key_next[i + BLOCK_WORDS] = cw_round[i];
                    end
                end
            end
            ST_PASS2:
            begin
                round_next = round_reg + ROUND_W'(1);
                cw_next    = cw_round;
                if (last_round)
                begin
                    round_next = '0;
                    for (int i = 0; i < BLOCK_WORDS; i++)
                    begin
                        h_next[i] = h_reg[i] ^ key_reg[i + BLOCK_WORDS];
                        g_next[i] = g_reg[i] ^ cw_round[i];
                    end
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    out_h_next     = h_reg;
                    out_g_next     = g_reg;
                    for (int i = 0; i < BLOCK_WORDS; i++)
                    begin
                        h_next[i] = '0;
                        g_next[i] = '0;
                    end
                end
            end
            default:
            begin
                round_next = '0;
            end
        endcase
    end

    // ---------------------------------------------------------------------
    // Registers. Control state and the chain reset; payload does not.
    // ---------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            round_reg     <= '0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < BLOCK_WORDS; i++)
            begin
                h_reg[i] <= '0;
                g_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            round_reg     <= round_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
            h_reg         <= h_next;
            g_reg         <= g_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cw_reg    <= cw_next;
        key_reg   <= key_next;
        out_h_reg <= out_h_next;
        out_g_reg <= out_g_next;
    end

    // Output channel.
    assign digest.valid     = out_valid_reg;
    assign digest.digest_h0 = out_h_reg[0];
    assign digest.digest_h1 = out_h_reg[1];
    assign digest.digest_h2 = out_h_reg[2];
    assign digest.digest_h3 = out_h_reg[3];
    assign digest.digest_g0 = out_g_reg[0];
    assign digest.digest_g1 = out_g_reg[1];
    assign digest.digest_g2 = out_g_reg[2];
    assign digest.digest_g3 = out_g_reg[3];

endmodule

>>> rtl/tdmh_check.sv
// Port-level checker for the Tandem-DM CHAM hash block, bound to its top level.
// Depends on tdmh_pkg for the word width and on the top level's channel ports.
module tdmh_check (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          blk_valid,
    input logic                          blk_ready,
    input logic                          dig_valid,
    input logic                          dig_ready,
    input logic [8*tdmh_pkg::WORD_W-1:0] dig_data
);
    import tdmh_pkg::*;

    // A digest that is not taken stays offered and unchanged.
    a_dig_hold: assert property (@(posedge clk) disable iff (!rst_n)
        dig_valid && !dig_ready |=> dig_valid && $stable(dig_data))
        else $error("digest dropped or changed while stalled");

    // After taking a block the block is busy and does not take another request at once.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        blk_valid && blk_ready |=> !blk_ready ##1 !blk_ready)
        else $error("block accepted a request while still busy");

    // A new digest only appears when the block was busy just before.
    a_dig_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(dig_valid) |-> !$past(blk_ready))
        else $error("digest appeared without hashing work");

    // Taking a block never produces a digest in the very next cycle.
    a_no_instant: assert property (@(posedge clk) disable iff (!rst_n)
        blk_valid && blk_ready |=> !$rose(dig_valid))
        else $error("digest appeared right after a block was taken");

endmodule

bind tandem_dm_hash_cham tdmh_check u_tdmh_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .blk_valid (blk.valid),
    .blk_ready (blk.ready),
    .dig_valid (digest.valid),
    .dig_ready (digest.ready),
    .dig_data  ({digest.digest_h0, digest.digest_h1, digest.digest_h2, digest.digest_h3,
                 digest.digest_g0, digest.digest_g1, digest.digest_g2, digest.digest_g3})
);

>>> tb/sv/tdmh_digest_checker.sv
// Digest checker for the Tandem-DM CHAM-128/256 hash block: watches both channels,
// predicts each digest from the accepted message blocks and compares it word by word.
// Depends on tdmh_pkg and on the tdmh_blk_if and tdmh_dig_if interfaces.
module tdmh_digest_checker #(
    parameter int ROUNDS = tdmh_pkg::ROUNDS_DEFAULT
) (
    input  logic clk,
    input  logic rst_n,
    tdmh_blk_if  blk,
    tdmh_dig_if  digest,
    output int   failures,
    output int   outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef tdmh_pkg::word_t [3:0]  quad_t;
    typedef tdmh_pkg::word_t [7:0]  cham_key_t;
    typedef tdmh_pkg::word_t [15:0] round_keys_t;

    typedef struct packed {
        quad_t h;
        quad_t g;
    } digest_t;

    quad_t   chain_h = '0;
    quad_t   chain_g = '0;
    quad_t   msg_words;
    quad_t   w_words;
    quad_t   e_words;
    digest_t seen;
    digest_t due;
    digest_t digests_due[$];

    function automatic tdmh_pkg::word_t rol(input tdmh_pkg::word_t x, input int unsigned n);
        logic [63:0] twice;
        twice = {x, x} << n;
        return twice[63:32];
    endfunction

    function automatic round_keys_t cham_round_keys(input cham_key_t key);
        round_keys_t     rk;
        tdmh_pkg::word_t base;
        for (int i = 0; i < 8; i++)
        begin
            base             = key[i] ^ rol(key[i], tdmh_pkg::ROT_A);
            rk[i]            = base ^ rol(key[i], tdmh_pkg::ROT_B);
            rk[(i + 8) ^ 1]  = base ^ rol(key[i], tdmh_pkg::ROT_KS);
        end
        return rk;
    endfunction

    // Even rounds rotate the second word by 1 and the sum by 8; odd rounds swap them.
    function automatic quad_t cham_encrypt(input quad_t plain, input cham_key_t key);
        round_keys_t     rk;
        quad_t           x;
        tdmh_pkg::word_t mixed;
        tdmh_pkg::word_t t;
        tdmh_pkg::word_t idx;
        rk = cham_round_keys(key);
        x  = plain;
        for (int r = 0; r < ROUNDS; r++)
        begin
            idx = tdmh_pkg::word_t'(r & 8'hFF);
            if (r % 2 == 0)
            begin
                mixed = rol(x[1], tdmh_pkg::ROT_A) ^ rk[r % 16];
                t     = rol((x[0] ^ idx) + mixed, tdmh_pkg::ROT_B);
            end
            else
            begin
                mixed = rol(x[1], tdmh_pkg::ROT_B) ^ rk[r % 16];
                t     = rol((x[0] ^ idx) + mixed, tdmh_pkg::ROT_A);
            end
            x = {t, x[3], x[2], x[1]};
        end
        return x;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chain_h = '0;
            chain_g = '0;
            digests_due.delete();
            failures    = 0;
            outstanding = 0;
        end
        else
        begin
            if (digest.valid && digest.ready)
            begin
                seen.h = {digest.digest_h3, digest.digest_h2, digest.digest_h1, digest.digest_h0};
                seen.g = {digest.digest_g3, digest.digest_g2, digest.digest_g1, digest.digest_g0};
                if (digests_due.size() == 0)
                begin
                    $error("digest request with no digest expected");
                    failures++;
                end
                else
                begin
                    due = digests_due.pop_front();
                    for (int i = 0; i < 4; i++)
                    begin
                        if (seen.h[i] !== due.h[i])
                        begin
                            $error("digest_h%0d: expected %08h, actual %08h", i, due.h[i], seen.h[i]);
                            failures++;
                        end
                        if (seen.g[i] !== due.g[i])
                        begin
                            $error("digest_g%0d: expected %08h, actual %08h", i, due.g[i], seen.g[i]);
                            failures++;
                        end
                    end
                end
            end

            if (blk.valid && blk.ready)
            begin
                msg_words = {blk.block_word3, blk.block_word2, blk.block_word1, blk.block_word0};
                // Key for the first pass is G||M, for the second M||W (word 0 lowest).
                w_words = cham_encrypt(chain_h, {msg_words, chain_g});
                e_words = cham_encrypt(chain_g, {w_words, msg_words});
                chain_h = chain_h ^ w_words;
                chain_g = chain_g ^ e_words;
                if (blk.last_block)
                begin
                    digests_due.push_back('{h: chain_h, g: chain_g});
                    chain_h = '0;
                    chain_g = '0;
                end
            end
            outstanding = digests_due.size();
        end
    end

endmodule

>>> tb/sv/testbench.sv
// Top of the testbench for tandem_dm_hash_cham: clock, reset, message stimulus,
// random stalls on the digest side, watchdog and final verdict.
// Depends on tdmh_pkg, both channel interfaces, the block and tdmh_digest_checker.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    typedef tdmh_pkg::word_t [3:0] quad_t;

    localparam int ROUNDS        = tdmh_pkg::ROUNDS_DEFAULT;
    // A block that closes a message occupies the block for its take, both passes and the hand-over of its digest.
    localparam int BLOCK_CYCLES  = 2 * ROUNDS + 2;
    localparam int LONG_GAP      = 60;
    // Longest quiet stretch of a correct run is one block time plus the longest
    // sender gap plus the longest digest stall; the limit takes that eight times over.
    localparam int WATCHDOG_LIMIT = 8 * (BLOCK_CYCLES + 2 * LONG_GAP);
    localparam int RANDOM_BLOCKS = 800;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    int failures;
    int outstanding;
    int idle_cycles = 0;
    int ready_hold  = 0;
    // When set, neither side starts new gaps, so the block runs back to back.
    bit steady = 1'b0;

    tdmh_blk_if blk();
    tdmh_dig_if digest();

    tandem_dm_hash_cham #(
        .ROUNDS(ROUNDS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .blk(blk),
        .digest(digest)
    );

    tdmh_digest_checker #(
        .ROUNDS(ROUNDS)
    ) digest_checker (
        .clk(clk),
        .rst_n(rst_n),
        .blk(blk),
        .digest(digest),
        .failures(failures),
        .outstanding(outstanding)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Mostly no gap or a short one, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, LONG_GAP);
    endfunction

    // Random message word with extra weight on all-zero, all-one and single-bit patterns,
    // so that every bit of every word sees both values in a few hundred requests.
    function automatic tdmh_pkg::word_t rand_word();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return '0;
        else if (r == 1)
            return '1;
        else if (r == 2)
            return tdmh_pkg::word_t'(1) << $urandom_range(0, 31);
        else if (r == 3)
            return ~(tdmh_pkg::word_t'(1) << $urandom_range(0, 31));
        return $urandom;
    endfunction

    function automatic quad_t rand_block();
        return {rand_word(), rand_word(), rand_word(), rand_word()};
    endfunction

    // Offer one message block and hold it until the block takes it. Inputs change
    // only at the falling edge; the handshake is judged at the rising edge.
    task automatic offer_block(input quad_t words, input logic last);
        int gap;
        gap = steady ? 0 : pick_gap();
        @(negedge clk);
        if (gap != 0)
        begin
            // Scramble words 0 and 3 and the last-block flag while valid is low; the block must ignore them.
            blk.valid       <= 1'b0;
            blk.block_word0 <= $urandom;
            blk.block_word3 <= $urandom;
            blk.last_block  <= $urandom_range(0, 1);
            repeat (gap) @(negedge clk);
        end
        blk.valid       <= 1'b1;
        blk.block_word0 <= words[0];
        blk.block_word1 <= words[1];
        blk.block_word2 <= words[2];
        blk.block_word3 <= words[3];
        blk.last_block  <= last;
        do
            @(posedge clk);
        while (!blk.ready);
    endtask

    // Stop sending and wait until every predicted digest has come out.
    task automatic drain_digests();
        @(negedge clk);
        blk.valid <= 1'b0;
        while (outstanding != 0)
            @(posedge clk);
    endtask

    // Digest side: ready drops for random stretches, but no new stretch starts while steady.
    always @(negedge clk)
    begin
        if (!rst_n)
            digest.ready <= 1'b0;
        else if (ready_hold != 0)
        begin
            ready_hold   <= ready_hold - 1;
            digest.ready <= 1'b0;
        end
        else
        begin
            digest.ready <= 1'b1;
            if (!steady && $urandom_range(0, 7) == 0)
                ready_hold <= pick_gap();
        end
    end

    // Watchdog: any accepted request on either channel restarts the count.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((blk.valid && blk.ready) || (digest.valid && digest.ready))
                idle_cycles <= 0;
            else if (idle_cycles + 1 >= WATCHDOG_LIMIT)
            begin
                $display("Test completed with failures");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        int sent;
        int msg_len;
        int r;

        blk.valid       = 1'b0;
        blk.block_word0 = '0;
        blk.block_word1 = '0;
        blk.block_word2 = '0;
        blk.block_word3 = '0;
        blk.last_block  = 1'b0;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part. Single-block messages at the extremes of the words; the
        // repeated all-zero message checks that the chain was cleared after a digest.
        offer_block({32'h0, 32'h0, 32'h0, 32'h0}, 1'b1);
        offer_block({32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b1);
        offer_block({32'h0, 32'h0, 32'h0, 32'h0}, 1'b1);
        offer_block({32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA}, 1'b1);
        offer_block({32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555}, 1'b1);
        offer_block({32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF}, 1'b1);
        offer_block({32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0}, 1'b1);
        offer_block({32'h8000_0000, 32'h0000_0001, 32'h8000_0000, 32'h0000_0001}, 1'b1);
        offer_block({32'h7FFF_FFFF, 32'hFFFF_FFFE, 32'h7FFF_FFFF, 32'hFFFF_FFFE}, 1'b1);

        // A four-block message: the chain must carry across the first three blocks,
        // which return nothing.
        offer_block({32'h0F0E_0D0C, 32'h0B0A_0908, 32'h0706_0504, 32'h0302_0100}, 1'b0);
        offer_block({32'h1F1E_1D1C, 32'h1B1A_1918, 32'h1716_1514, 32'h1312_1110}, 1'b0);
        offer_block({32'h2F2E_2D2C, 32'h2B2A_2928, 32'h2726_2524, 32'h2322_2120}, 1'b0);
        offer_block({32'h3F3E_3D3C, 32'h3B3A_3938, 32'h3736_3534, 32'h3332_3130}, 1'b1);

        // Two-block messages at opposite extremes.
        offer_block({32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b0);
        offer_block({32'h0, 32'h0, 32'h0, 32'h0}, 1'b1);
        offer_block({32'h0, 32'h0, 32'h0, 32'h0}, 1'b0);
        offer_block({32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b1);

        // Let the digest side catch up completely before the random part.
        drain_digests();

        // Random part: whole messages of random length with random content, mostly
        // short so that digests come often, with the odd long message in between.
        sent = 0;
        while (sent < RANDOM_BLOCKS)
        begin
            steady = ($urandom_range(0, 4) == 0);
            r = $urandom_range(0, 99);
            if (r < 40)
                msg_len = 1;
            else if (r < 75)
                msg_len = $urandom_range(2, 4);
            else if (r < 95)
                msg_len = $urandom_range(5, 10);
            else
                msg_len = $urandom_range(16, 40);

            for (int b = 0; b < msg_len; b++)
                offer_block(rand_block(), b == msg_len - 1);
            sent += msg_len;

            // A second full drain half way through.
            if (sent >= RANDOM_BLOCKS / 2 && sent - msg_len < RANDOM_BLOCKS / 2)
                drain_digests();
        end
        steady = 1'b0;

        @(negedge clk);
        blk.valid <= 1'b0;
        while (outstanding != 0)
            @(posedge clk);
        // Allow one more block time for any stray digest to show up.
        repeat (BLOCK_CYCLES + 2) @(posedge clk);

        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
